[src/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/hcb_pkg.sv]
// Constants and entry types for the code builder.
// No dependencies.
`default_nettype none

package hcb_pkg;
    localparam int SYMBOLS    = 16;
    localparam int FREQ_WIDTH = 16;

    localparam int SYM_W    = 8;
    localparam int FIN_W    = 16;
    localparam int CODE_W   = 15;
    localparam int LEN_W    = 4;
    localparam int FEFF_W   = (FREQ_WIDTH < FIN_W) ? FREQ_WIDTH : FIN_W;
    localparam logic [FIN_W-1:0] FREQ_MASK = FIN_W'((64'd1 << FEFF_W) - 64'd1);

    localparam int NODE_CAP = 2 * SYMBOLS;
    localparam int NODE_W   = $clog2(NODE_CAP);
    localparam int SLOT_W   = $clog2(SYMBOLS);
    localparam int CNT_W    = $clog2(SYMBOLS + 1);
    localparam int SP_W     = $clog2(NODE_CAP + 1);
    localparam int WEIGHT_W = FEFF_W + $clog2(SYMBOLS);

    typedef struct packed {
        logic [NODE_W-1:0]   node;
        logic [WEIGHT_W-1:0] weight;
    } t_heap_ent;

    typedef struct packed {
        logic              inner;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [SYM_W-1:0]  symbol;
    } t_node;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_walk;
endpackage

`default_nettype wire

[src/hcb_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

[src/huffman_code_builder.sv]
// Top level of the code builder: load sequencer, heap build/merge, tree walk.
// Depends on hcb_pkg and hcb_ram.
`default_nettype none

// Pairs load one per cycle while busy is low. The pair with last_pair set
// raises busy; the block then builds the heap, merges, and walks the tree,
// all through three single-read-port memories (heap, node store, walk
// stack). Each sift moves down the heap one level at a time, each take
// moves the last entry to the top and sifts it down, each insert climbs
// one level at a time, and the walk pops each node and pushes both
// children of an inner node. One result per leaf appears on the result
// ports for one cycle with o_valid high; the receiver cannot stall, so it
// must take every strobe. busy falls after the final result.
module huffman_code_builder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [hcb_pkg::SYM_W-1:0] i_symbol,
    input  logic [hcb_pkg::FIN_W-1:0] i_frequency,
    input  logic                      i_last_pair,
    output logic                      o_valid,
    output logic [hcb_pkg::SYM_W-1:0]  o_leaf_symbol,
    output logic [hcb_pkg::CODE_W-1:0] o_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]  o_code_length,
    output logic                      o_last_code,
    output logic                      o_dropped
);
    import hcb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LOADK, S_CAPK, S_SDA, S_SDB, S_SDC, S_CHK, S_TK0, S_TK1,
        S_TK2, S_MERGE, S_PUA, S_PUB, S_ROOT, S_ROOTC, S_POP, S_POPC, S_NODE,
        S_PUSHL
    } t_state;

    typedef enum logic [1:0] {C_BUILD, C_TAKE_A, C_TAKE_B} t_ctx;

    t_state            r_state;
    t_ctx              r_ctx;
    logic [CNT_W-1:0]  r_node_cnt;
    logic [NODE_W-1:0] r_nodes;
    logic [CNT_W-1:0]  r_hc;
    logic              r_over;
    logic [SLOT_W-1:0] r_k;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_small;
    logic [SLOT_W-1:0] r_pi;
    t_heap_ent         r_cur;
    t_heap_ent         r_es;
    t_heap_ent         r_a;
    t_heap_ent         r_b;
    t_heap_ent         r_new;
    logic [SP_W-1:0]   r_sp;
    t_walk             r_walk;
    logic [NODE_W-1:0] r_left;
    logic [CNT_W-1:0]  r_emitted;
    logic              r_valid;
    logic [SYM_W-1:0]  r_sym;
    logic [CODE_W-1:0] r_code;
    logic [LEN_W-1:0]  r_len;
    logic              r_last;
    logic              r_drop;

    // memory ports
    logic              h_we;
    logic [SLOT_W-1:0] h_waddr;
    t_heap_ent         h_wdata;
    logic [SLOT_W-1:0] h_raddr;
    t_heap_ent         h_rdata;
    logic              nd_we;
    logic [NODE_W-1:0] nd_waddr;
    t_node             nd_wdata;
    logic [NODE_W-1:0] nd_raddr;
    t_node             nd_rdata;
    logic              st_we;
    logic [NODE_W-1:0] st_waddr;
    t_walk             st_wdata;
    logic [NODE_W-1:0] st_raddr;
    t_walk             st_rdata;

    hcb_ram #(.WIDTH($bits(t_heap_ent)), .DEPTH(SYMBOLS)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );
    hcb_ram #(.WIDTH($bits(t_node)), .DEPTH(NODE_CAP)) u_nodes (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(nd_waddr), .i_wdata(nd_wdata),
        .i_raddr(nd_raddr), .o_rdata(nd_rdata)
    );
    hcb_ram #(.WIDTH($bits(t_walk)), .DEPTH(NODE_CAP)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata)
    );

    logic                room;
    logic [CNT_W-1:0]    leaves_n;
    logic [SLOT_W-1:0]   start_k;
    logic [SLOT_W+1:0]   l_idx;
    logic [SLOT_W+1:0]   r_idx_c;
    logic [SLOT_W+1:0]   hc_x;
    logic                l_ok;
    logic                r_ok;
    logic                take_l;
    logic                take_r;
    logic [SLOT_W-1:0]   fin_small;
    t_heap_ent           fin_ent;
    logic                sift_done;
    logic [SLOT_W-1:0]   parent;
    logic [FIN_W-1:0]    freq_m;

    always_comb begin
        room     = r_node_cnt < CNT_W'(SYMBOLS);
        leaves_n = room ? r_node_cnt + CNT_W'(1) : r_node_cnt;
        start_k  = (leaves_n > CNT_W'(1)) ? SLOT_W'((leaves_n - CNT_W'(2)) >> 1) : '0;
        freq_m   = i_frequency & FREQ_MASK;
        l_idx    = ({2'b00, r_idx} << 1) + (SLOT_W+2)'(1);
        r_idx_c  = l_idx + (SLOT_W+2)'(1);
        hc_x     = (SLOT_W+2)'(r_hc);
        l_ok     = l_idx < hc_x;
        r_ok     = r_idx_c < hc_x;
        take_l   = h_rdata.weight < r_cur.weight;
        take_r   = r_ok && (h_rdata.weight < r_es.weight);
        fin_small = take_r ? r_idx_c[SLOT_W-1:0] : r_small;
        fin_ent   = take_r ? h_rdata : r_es;
        sift_done = fin_small == r_idx;
        parent    = (r_pi - SLOT_W'(1)) >> 1;
    end

    always_comb begin
        h_we     = 1'b0;
        h_waddr  = r_idx;
        h_wdata  = r_cur;
        h_raddr  = '0;
        nd_we    = 1'b0;
        nd_waddr = r_nodes;
        nd_wdata = '{inner: 1'b1, left: r_a.node, right: r_b.node, symbol: '0};
        nd_raddr = st_rdata.node;
        st_we    = 1'b0;
        st_waddr = r_sp[NODE_W-1:0];
        st_wdata = '{node: r_left, code: r_walk.code << 1,
                     len: r_walk.len + LEN_W'(1)};
        st_raddr = r_sp[NODE_W-1:0] - NODE_W'(1);
        case (r_state)
            S_IDLE: begin
                if (start && room) begin
                    h_we     = 1'b1;
                    h_waddr  = SLOT_W'(r_node_cnt);
                    h_wdata  = '{node: NODE_W'(r_node_cnt), weight: WEIGHT_W'(freq_m)};
                    nd_we    = 1'b1;
                    nd_waddr = NODE_W'(r_node_cnt);
                    nd_wdata = '{inner: 1'b0, left: '0, right: '0, symbol: i_symbol};
                end
            end
            S_LOADK: h_raddr = r_k;
            S_SDA: begin
                h_raddr = l_idx[SLOT_W-1:0];
                h_we    = !l_ok;
            end
            S_SDB: h_raddr = r_idx_c[SLOT_W-1:0];
            S_SDC: begin
                h_we    = 1'b1;
                h_wdata = sift_done ? r_cur : fin_ent;
            end
            S_TK1: h_raddr = SLOT_W'(r_hc - CNT_W'(1));
            S_MERGE: nd_we = 1'b1;
            S_PUA: begin
                h_raddr = parent;
                h_we    = r_pi == '0;
                h_waddr = r_pi;
                h_wdata = r_new;
            end
            S_PUB: begin
                h_we    = 1'b1;
                h_waddr = r_pi;
                h_wdata = (r_new.weight < h_rdata.weight) ? h_rdata : r_new;
            end
            S_ROOTC: begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = '{node: h_rdata.node, code: '0, len: '0};
            end
            S_NODE: begin
                st_we    = nd_rdata.inner;
                st_wdata = '{node: nd_rdata.right,
                             code: (r_walk.code << 1) | CODE_W'(1),
                             len: r_walk.len + LEN_W'(1)};
            end
            S_PUSHL: st_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ctx      <= C_BUILD;
            r_node_cnt <= '0;
            r_nodes    <= '0;
            r_hc       <= '0;
            r_over     <= 1'b0;
            r_sp       <= '0;
            r_emitted  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (room) begin
                            r_node_cnt <= r_node_cnt + CNT_W'(1);
                        end else begin
                            r_over <= 1'b1;
                        end
                        if (i_last_pair) begin
                            r_nodes <= NODE_W'(leaves_n);
                            r_hc    <= leaves_n;
                            r_k     <= start_k;
                            r_ctx   <= C_BUILD;
                            r_state <= S_LOADK;
                        end
                    end
                end
                S_LOADK: r_state <= S_CAPK;
                S_CAPK: begin
                    r_cur   <= h_rdata;
                    r_idx   <= r_k;
                    r_state <= S_SDA;
                end
                S_SDA: begin
                    r_state <= l_ok ? S_SDB : S_CHK;
                    if (!l_ok) begin
                        // leaf position reached: cur already written back
                        case (r_ctx)
                            C_BUILD: begin
                                if (r_k != '0) begin
                                    r_k     <= r_k - SLOT_W'(1);
                                    r_state <= S_LOADK;
                                end
                            end
                            C_TAKE_A: begin
                                r_ctx   <= C_TAKE_B;
                                r_state <= S_TK0;
                            end
                            C_TAKE_B: r_state <= S_MERGE;
                            default: ;
                        endcase
                    end
                end
                S_SDB: begin
                    r_small <= take_l ? l_idx[SLOT_W-1:0] : r_idx;
                    r_es    <= take_l ? h_rdata : r_cur;
                    r_state <= S_SDC;
                end
                S_SDC: begin
                    if (!sift_done) begin
                        r_idx   <= fin_small;
                        r_state <= S_SDA;
                    end else begin
                        r_state <= S_CHK;
                        case (r_ctx)
                            C_BUILD: begin
                                if (r_k != '0) begin
                                    r_k     <= r_k - SLOT_W'(1);
                                    r_state <= S_LOADK;
                                end
                            end
                            C_TAKE_A: begin
                                r_ctx   <= C_TAKE_B;
                                r_state <= S_TK0;
                            end
                            C_TAKE_B: r_state <= S_MERGE;
                            default: ;
                        endcase
                    end
                end
                S_CHK: begin
                    if (r_hc > CNT_W'(1)) begin
                        r_ctx   <= C_TAKE_A;
                        r_state <= S_TK0;
                    end else begin
                        r_state <= S_ROOT;
                    end
                end
                S_TK0: r_state <= S_TK1;
                S_TK1: begin
                    if (r_ctx == C_TAKE_A) begin
                        r_a <= h_rdata;
                    end else begin
                        r_b <= h_rdata;
                    end
                    r_state <= S_TK2;
                end
                S_TK2: begin
                    // last entry fills the hole at the top and sifts down
                    r_cur   <= h_rdata;
                    r_hc    <= r_hc - CNT_W'(1);
                    r_idx   <= '0;
                    r_state <= S_SDA;
                end
                S_MERGE: begin
                    r_new   <= '{node: r_nodes, weight: r_a.weight + r_b.weight};
                    r_pi    <= SLOT_W'(r_hc);
                    r_hc    <= r_hc + CNT_W'(1);
                    r_nodes <= r_nodes + NODE_W'(1);
                    r_state <= S_PUA;
                end
                S_PUA: r_state <= (r_pi == '0) ? S_CHK : S_PUB;
                S_PUB: begin
                    if (r_new.weight < h_rdata.weight) begin
                        r_pi    <= parent;
                        r_state <= S_PUA;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_ROOT: r_state <= S_ROOTC;
                S_ROOTC: begin
                    r_sp    <= SP_W'(1);
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_node_cnt <= '0;
                        r_hc       <= '0;
                        r_over     <= 1'b0;
                        r_emitted  <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_sp    <= r_sp - SP_W'(1);
                        r_state <= S_POPC;
                    end
                end
                S_POPC: begin
                    r_walk  <= st_rdata;
                    r_state <= S_NODE;
                end
                S_NODE: begin
                    if (nd_rdata.inner) begin
                        r_left  <= nd_rdata.left;
                        r_sp    <= r_sp + SP_W'(1);
                        r_state <= S_PUSHL;
                    end else begin
                        r_valid   <= 1'b1;
                        r_sym     <= nd_rdata.symbol;
                        r_code    <= r_walk.code;
                        r_len     <= r_walk.len;
                        r_last    <= (r_emitted + CNT_W'(1)) == r_node_cnt;
                        r_drop    <= r_over;
                        r_emitted <= r_emitted + CNT_W'(1);
                        r_state   <= S_POP;
                    end
                end
                S_PUSHL: begin
                    r_sp    <= r_sp + SP_W'(1);
                    r_state <= S_POP;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy          = r_state != S_IDLE;
    assign o_valid       = r_valid;
    assign o_leaf_symbol = r_sym;
    assign o_code_bits   = r_code;
    assign o_code_length = r_len;
    assign o_last_code   = r_last;
    assign o_dropped     = r_drop;
endmodule

`default_nettype wire

[src/hcb_checker.sv]
// Port-level checks for the code builder, bound to the top level.
// Depends on hcb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hcb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       i_last_pair,
    input logic                       o_valid,
    input logic                       o_last_code
);
    import hcb_pkg::*;

    logic accept;
    assign accept = start && !busy;

    `ASSERT_SAME(a_valid_busy, i_clk, i_rst_n, o_valid, busy, "result outside a build")
    `ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, accept && i_last_pair, busy, "closing transaction did not start build")
    `ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, accept && !i_last_pair, !busy, "load transaction raised busy")
    `ASSERT_NEXT(a_last_end, i_clk, i_rst_n, o_valid && o_last_code, !o_valid, "result after final code")
endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_last_pair(i_last_pair), .o_valid(o_valid), .o_last_code(o_last_code)
);

`default_nettype wire
